>>> sv/line_rasterizer_assert.svh
// ----------------------------------------------------------------------------
// line_rasterizer_assert: assertion macros
// Clocked checks with reset disable, same-cycle and next-cycle forms.
// ----------------------------------------------------------------------------
`ifndef LINE_RASTERIZER_ASSERT_SVH
`define LINE_RASTERIZER_ASSERT_SVH

// check cons in the cycle where ante holds
`define LR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// check cons in the cycle after ante holds
`define LR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/lr_pkg.sv
// ----------------------------------------------------------------------------
// lr_pkg: line rasterizer package
// Widths, operation and algorithm codes, controller types.
// ----------------------------------------------------------------------------
package lr_pkg;

   localparam int CoordW  = 12;
   localparam int PosW    = 13;
   localparam int DeltaW  = 13;
   localparam int DblW    = 14;
   localparam int ErrW    = 16;
   localparam int FracW   = 16;
   localparam int FixW    = 29;
   localparam int IncW    = 18;
   localparam int QuotW   = 17;
   localparam int StepsW  = 13;
   localparam int ColorW  = 32;
   localparam int IndexW  = 20;
   localparam int AlgW    = 2;

   localparam int DEF_FRAME_WIDTH  = 1024;
   localparam int DEF_FRAME_HEIGHT = 768;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_NEXT = 1'b1;

   localparam logic [AlgW-1:0] ALG_DDA  = 2'd0;
   localparam logic [AlgW-1:0] ALG_BRES = 2'd1;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_DIVIDE = 3'b010,
      ST_EMIT   = 3'b100
   } lr_state_type;

   typedef struct packed {
      logic accept;
      logic dda_emit;
   } lr_cmd_type;

   typedef struct packed {
      logic dda_long;
      logic div_busy;
   } lr_status_type;

endpackage

>>> sv/line_rasterizer.sv
// ----------------------------------------------------------------------------
// line_rasterizer: line pixel generator
// Timing: a result is registered in the cycle after its request is taken; a
// DDA load with nonzero steps waits in DIVIDE on the bit-serial increment divider, then EMIT.
// Throughput: 1 request per cycle for next-pixel and Bresenham loads, set by
// the step adder, while the result slot is free; a DDA load blocks requests until it emits.
// Reset: synchronous, clears the controller, result valid and active line.
// ----------------------------------------------------------------------------
`include "line_rasterizer_assert.svh"

module line_rasterizer
   import lr_pkg::*;
#(
   parameter int FRAME_WIDTH  = DEF_FRAME_WIDTH,
   parameter int FRAME_HEIGHT = DEF_FRAME_HEIGHT
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_operation,
   input  logic signed [CoordW-1:0] req_start_x,
   input  logic signed [CoordW-1:0] req_start_y,
   input  logic signed [CoordW-1:0] req_end_x,
   input  logic signed [CoordW-1:0] req_end_y,
   input  logic [ColorW-1:0]        req_pixel_color,
   input  logic [AlgW-1:0]          req_algorithm,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_pixel_present,
   output logic                     rsp_write_enable,
   output logic signed [CoordW-1:0] rsp_pixel_x,
   output logic signed [CoordW-1:0] rsp_pixel_y,
   output logic [IndexW-1:0]        rsp_pixel_index,
   output logic [ColorW-1:0]        rsp_out_color,
   output logic                     rsp_last
);

   lr_cmd_type    cmd;
   lr_status_type status;

   lr_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lr_datapath #(
      .FRAME_WIDTH  (FRAME_WIDTH),
      .FRAME_HEIGHT (FRAME_HEIGHT)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_operation     (req_operation),
      .req_start_x       (req_start_x),
      .req_start_y       (req_start_y),
      .req_end_x         (req_end_x),
      .req_end_y         (req_end_y),
      .req_pixel_color   (req_pixel_color),
      .req_algorithm     (req_algorithm),
      .rsp_pixel_present (rsp_pixel_present),
      .rsp_write_enable  (rsp_write_enable),
      .rsp_pixel_x       (rsp_pixel_x),
      .rsp_pixel_y       (rsp_pixel_y),
      .rsp_pixel_index   (rsp_pixel_index),
      .rsp_out_color     (rsp_out_color),
      .rsp_last          (rsp_last)
   );

   `LR_ASSERT_SAME(a_no_take_when_stalled, clock, reset, rsp_valid && !rsp_ready, !req_ready, "request taken while result stalled")
   `LR_ASSERT_SAME(a_empty_is_last, clock, reset, rsp_valid && !rsp_pixel_present, rsp_last && !rsp_write_enable, "empty result not marked last")
   `LR_ASSERT_SAME(a_write_needs_pixel, clock, reset, rsp_valid && rsp_write_enable, rsp_pixel_present && (rsp_pixel_x != 0) && (rsp_pixel_y != 0), "write enable without drawable pixel")
   `LR_ASSERT_NEXT(a_next_one_cycle, clock, reset, req_valid && req_ready && (req_operation == OP_NEXT), rsp_valid, "next-pixel request gave no result")

endmodule

>>> sv/lr_divider.sv
// ----------------------------------------------------------------------------
// lr_divider: DDA increment divider
// Two-lane restoring divider, one quotient bit per lane per cycle,
// computing floor(num * 2^16 / den) for num <= den.
// ----------------------------------------------------------------------------
module lr_divider
   import lr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DeltaW-1:0] num_x,
   input  logic [DeltaW-1:0] num_y,
   input  logic [DeltaW-1:0] den,
   output logic              busy,
   output logic [QuotW-1:0]  quot_x,
   output logic [QuotW-1:0]  quot_y
);

   localparam int CntW = $clog2(QuotW + 1);
   localparam int RemW = DeltaW + 1;

   logic [CntW-1:0]   count_ff, count_in;
   logic [RemW-1:0]   rem_x_ff, rem_x_in, rem_y_ff, rem_y_in;
   logic [DeltaW-1:0] den_ff, den_in;
   logic [QuotW-1:0]  q_x_ff, q_x_in, q_y_ff, q_y_in;
   logic              ge_x, ge_y;
   logic [RemW-1:0]   r_x, r_y;

   always_comb begin
      ge_x     = rem_x_ff >= RemW'(den_ff);
      ge_y     = rem_y_ff >= RemW'(den_ff);
      r_x      = ge_x ? rem_x_ff - RemW'(den_ff) : rem_x_ff;
      r_y      = ge_y ? rem_y_ff - RemW'(den_ff) : rem_y_ff;
      count_in = count_ff;
      rem_x_in = rem_x_ff;
      rem_y_in = rem_y_ff;
      den_in   = den_ff;
      q_x_in   = q_x_ff;
      q_y_in   = q_y_ff;
      if (start) begin
         count_in = CntW'(QuotW);
         rem_x_in = RemW'(num_x);
         rem_y_in = RemW'(num_y);
         den_in   = den;
         q_x_in   = '0;
         q_y_in   = '0;
      end else if (busy) begin
         count_in = count_ff - 1'b1;
         rem_x_in = {r_x[DeltaW-1:0], 1'b0};
         rem_y_in = {r_y[DeltaW-1:0], 1'b0};
         q_x_in   = {q_x_ff[QuotW-2:0], ge_x};
         q_y_in   = {q_y_ff[QuotW-2:0], ge_y};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      rem_x_ff <= rem_x_in;
      rem_y_ff <= rem_y_in;
      den_ff   <= den_in;
      q_x_ff   <= q_x_in;
      q_y_ff   <= q_y_in;
   end

   assign busy   = count_ff != '0;
   assign quot_x = q_x_ff;
   assign quot_y = q_y_ff;

endmodule

>>> sv/lr_datapath.sv
// ----------------------------------------------------------------------------
// lr_datapath: line rasterizer datapath
// Line state, Bresenham and DDA step logic, increment divider and the
// result register with frame index and write enable.
// ----------------------------------------------------------------------------
module lr_datapath
   import lr_pkg::*;
#(
   parameter int FRAME_WIDTH  = DEF_FRAME_WIDTH,
   parameter int FRAME_HEIGHT = DEF_FRAME_HEIGHT
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  lr_cmd_type               cmd,
   output lr_status_type            status,
   input  logic                     req_operation,
   input  logic signed [CoordW-1:0] req_start_x,
   input  logic signed [CoordW-1:0] req_start_y,
   input  logic signed [CoordW-1:0] req_end_x,
   input  logic signed [CoordW-1:0] req_end_y,
   input  logic [ColorW-1:0]        req_pixel_color,
   input  logic [AlgW-1:0]          req_algorithm,
   output logic                     rsp_pixel_present,
   output logic                     rsp_write_enable,
   output logic signed [CoordW-1:0] rsp_pixel_x,
   output logic signed [CoordW-1:0] rsp_pixel_y,
   output logic [IndexW-1:0]        rsp_pixel_index,
   output logic [ColorW-1:0]        rsp_out_color,
   output logic                     rsp_last
);

   localparam int IdxW = PosW + $clog2(FRAME_WIDTH) + 2;
   localparam logic signed [IdxW-1:0] WidthS    = IdxW'(FRAME_WIDTH);
   localparam logic signed [IdxW-1:0] FrameSize = IdxW'(FRAME_WIDTH * FRAME_HEIGHT);
   localparam logic [FixW-1:0]        HalfLsb   = FixW'(1) << (FracW - 1);

   function automatic logic signed [PosW-1:0] round_q16(input logic signed [FixW-1:0] p);
      logic [FixW-1:0] mag;
      logic [FixW-1:0] sum;
      logic [PosW-1:0] r;
      mag = p[FixW-1] ? FixW'(-p) : FixW'(p);
      sum = mag + HalfLsb;
      r   = sum[FracW +: PosW];
      return p[FixW-1] ? PosW'(-r) : r;
   endfunction

   function automatic logic signed [1:0] sign_of(input logic signed [PosW-1:0] v);
      return (v == '0) ? 2'sb00 : (v[PosW-1] ? 2'sb11 : 2'sb01);
   endfunction

   // line state
   logic                     active_ff, active_in;
   logic                     use_bres_ff, use_bres_in;
   logic                     x_major_ff, x_major_in;
   logic signed [1:0]        step_x_ff, step_x_in, step_y_ff, step_y_in;
   logic signed [PosW-1:0]   cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic signed [CoordW-1:0] tgt_x_ff, tgt_x_in, tgt_y_ff, tgt_y_in;
   logic [DblW-1:0]          dbl_dx_ff, dbl_dx_in, dbl_dy_ff, dbl_dy_in;
   logic signed [ErrW-1:0]   err_ff, err_in;
   logic signed [FixW-1:0]   pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic signed [IncW-1:0]   inc_x_ff, inc_x_in, inc_y_ff, inc_y_in;
   logic [StepsW-1:0]        steps_left_ff, steps_left_in;
   logic [ColorW-1:0]        color_ff, color_in;

   // result register
   logic                     out_present_ff, out_present_in;
   logic signed [PosW-1:0]   out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic [ColorW-1:0]        out_color_ff, out_color_in;
   logic                     out_last_ff, out_last_in;

   // load terms
   logic signed [PosW-1:0]   sx, sy, ex, ey, dx, dy;
   logic [DeltaW-1:0]        adx, ady, steps;
   logic                     ld_x_major;
   logic signed [ErrW-1:0]   ld_err;

   // step terms
   logic                     bres_take, major_pos, bres_last, dda_last;
   logic [DblW-1:0]          d_major, d_minor;
   logic signed [ErrW-1:0]   bres_err_n;
   logic signed [PosW-1:0]   bres_x_n, bres_y_n;
   logic signed [PosW-1:0]   rnd_x, rnd_y;
   logic signed [IncW-1:0]   inc_div_x, inc_div_y, inc_use_x, inc_use_y;
   logic                     do_dda, do_bres, do_load, emit_empty;

   // divider
   logic                     div_busy;
   logic [QuotW-1:0]         quot_x, quot_y;

   // index
   logic signed [IdxW-1:0]   idx;

   lr_divider u_divider (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.accept && status.dda_long),
      .num_x  (adx),
      .num_y  (ady),
      .den    (steps),
      .busy   (div_busy),
      .quot_x (quot_x),
      .quot_y (quot_y)
   );

   always_comb begin
      sx  = PosW'(req_start_x);
      sy  = PosW'(req_start_y);
      ex  = PosW'(req_end_x);
      ey  = PosW'(req_end_y);
      dx  = ex - sx;
      dy  = ey - sy;
      adx = dx[PosW-1] ? DeltaW'(-dx) : DeltaW'(dx);
      ady = dy[PosW-1] ? DeltaW'(-dy) : DeltaW'(dy);
      steps      = (adx > ady) ? adx : ady;
      ld_x_major = adx >= ady;
      ld_err     = ld_x_major ? ErrW'({ady, 1'b0}) - ErrW'(adx)
                              : ErrW'({adx, 1'b0}) - ErrW'(ady);
   end

   assign status.dda_long = (req_operation == OP_LOAD) && (req_algorithm == ALG_DDA)
                            && (steps != '0);
   assign status.div_busy = div_busy;

   always_comb begin
      major_pos  = x_major_ff ? (step_x_ff == 2'sb01) : (step_y_ff == 2'sb01);
      bres_take  = (err_ff > 0) || ((err_ff == '0) && major_pos);
      d_major    = x_major_ff ? dbl_dx_ff : dbl_dy_ff;
      d_minor    = x_major_ff ? dbl_dy_ff : dbl_dx_ff;
      bres_err_n = err_ff + ErrW'(d_minor) - (bres_take ? ErrW'(d_major) : '0);
      bres_x_n   = cur_x_ff + ((x_major_ff || bres_take) ? PosW'(step_x_ff) : '0);
      bres_y_n   = cur_y_ff + ((!x_major_ff || bres_take) ? PosW'(step_y_ff) : '0);
      bres_last  = x_major_ff ? (bres_x_n == PosW'(tgt_x_ff))
                              : (bres_y_n == PosW'(tgt_y_ff));
      rnd_x      = round_q16(pos_x_ff);
      rnd_y      = round_q16(pos_y_ff);
      dda_last   = steps_left_ff == StepsW'(1);
      inc_div_x  = step_x_ff[1] ? -IncW'(quot_x) : IncW'(quot_x);
      inc_div_y  = step_y_ff[1] ? -IncW'(quot_y) : IncW'(quot_y);
      inc_use_x  = cmd.dda_emit ? inc_div_x : inc_x_ff;
      inc_use_y  = cmd.dda_emit ? inc_div_y : inc_y_ff;
      do_dda     = cmd.dda_emit || (cmd.accept && (req_operation == OP_NEXT)
                   && active_ff && !use_bres_ff);
      do_bres    = cmd.accept && (req_operation == OP_NEXT) && active_ff && use_bres_ff;
      do_load    = cmd.accept && (req_operation == OP_LOAD);
   end

   always_comb begin
      active_in      = active_ff;
      use_bres_in    = use_bres_ff;
      x_major_in     = x_major_ff;
      step_x_in      = step_x_ff;
      step_y_in      = step_y_ff;
      cur_x_in       = cur_x_ff;
      cur_y_in       = cur_y_ff;
      tgt_x_in       = tgt_x_ff;
      tgt_y_in       = tgt_y_ff;
      dbl_dx_in      = dbl_dx_ff;
      dbl_dy_in      = dbl_dy_ff;
      err_in         = err_ff;
      pos_x_in       = pos_x_ff;
      pos_y_in       = pos_y_ff;
      inc_x_in       = inc_x_ff;
      inc_y_in       = inc_y_ff;
      steps_left_in  = steps_left_ff;
      color_in       = color_ff;
      out_present_in = out_present_ff;
      out_x_in       = out_x_ff;
      out_y_in       = out_y_ff;
      out_color_in   = out_color_ff;
      out_last_in    = out_last_ff;
      emit_empty     = 1'b0;

      if (do_dda) begin
         out_present_in = 1'b1;
         out_x_in       = rnd_x;
         out_y_in       = rnd_y;
         out_color_in   = color_ff;
         out_last_in    = dda_last;
         pos_x_in       = pos_x_ff + FixW'(inc_use_x);
         pos_y_in       = pos_y_ff + FixW'(inc_use_y);
         inc_x_in       = inc_use_x;
         inc_y_in       = inc_use_y;
         steps_left_in  = steps_left_ff - 1'b1;
         active_in      = !dda_last;
      end else if (do_bres) begin
         out_present_in = 1'b1;
         out_x_in       = bres_x_n;
         out_y_in       = bres_y_n;
         out_color_in   = color_ff;
         out_last_in    = bres_last;
         cur_x_in       = bres_x_n;
         cur_y_in       = bres_y_n;
         err_in         = bres_err_n;
         active_in      = !bres_last;
      end else if (do_load) begin
         tgt_x_in  = req_end_x;
         tgt_y_in  = req_end_y;
         color_in  = req_pixel_color;
         step_x_in = sign_of(dx);
         step_y_in = sign_of(dy);
         active_in = 1'b0;
         case (req_algorithm)
            ALG_DDA: begin
               use_bres_in   = 1'b0;
               steps_left_in = StepsW'(steps);
               pos_x_in      = FixW'(signed'({req_start_x, FracW'(0)}));
               pos_y_in      = FixW'(signed'({req_start_y, FracW'(0)}));
               emit_empty    = steps == '0;
            end
            ALG_BRES: begin
               use_bres_in    = 1'b1;
               dbl_dx_in      = {adx, 1'b0};
               dbl_dy_in      = {ady, 1'b0};
               x_major_in     = ld_x_major;
               err_in         = ld_err;
               cur_x_in       = sx;
               cur_y_in       = sy;
               out_present_in = 1'b1;
               out_x_in       = sx;
               out_y_in       = sy;
               out_color_in   = req_pixel_color;
               out_last_in    = ld_x_major ? (sx == ex) : (sy == ey);
               active_in      = !out_last_in;
            end
            default: begin
               emit_empty = 1'b1;
            end
         endcase
      end else if (cmd.accept) begin
         emit_empty = 1'b1;
      end

      if (emit_empty) begin
         out_present_in = 1'b0;
         out_x_in       = '0;
         out_y_in       = '0;
         out_color_in   = '0;
         out_last_in    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
      use_bres_ff    <= use_bres_in;
      x_major_ff     <= x_major_in;
      step_x_ff      <= step_x_in;
      step_y_ff      <= step_y_in;
      cur_x_ff       <= cur_x_in;
      cur_y_ff       <= cur_y_in;
      tgt_x_ff       <= tgt_x_in;
      tgt_y_ff       <= tgt_y_in;
      dbl_dx_ff      <= dbl_dx_in;
      dbl_dy_ff      <= dbl_dy_in;
      err_ff         <= err_in;
      pos_x_ff       <= pos_x_in;
      pos_y_ff       <= pos_y_in;
      inc_x_ff       <= inc_x_in;
      inc_y_ff       <= inc_y_in;
      steps_left_ff  <= steps_left_in;
      color_ff       <= color_in;
      out_present_ff <= out_present_in;
      out_x_ff       <= out_x_in;
      out_y_ff       <= out_y_in;
      out_color_ff   <= out_color_in;
      out_last_ff    <= out_last_in;
   end

   // frame index from the held pixel
   assign idx = IdxW'(out_y_ff) * WidthS + IdxW'(out_x_ff);

   assign rsp_pixel_present = out_present_ff;
   assign rsp_write_enable  = out_present_ff && (out_x_ff != '0) && (out_y_ff != '0)
                              && !idx[IdxW-1] && (idx < FrameSize);
   assign rsp_pixel_x       = out_x_ff[CoordW-1:0];
   assign rsp_pixel_y       = out_y_ff[CoordW-1:0];
   assign rsp_pixel_index   = rsp_write_enable ? IndexW'(unsigned'(idx)) : '0;
   assign rsp_out_color     = out_color_ff;
   assign rsp_last          = out_last_ff;

endmodule

>>> sv/lr_controller.sv
// ----------------------------------------------------------------------------
// lr_controller: line rasterizer controller
// Request handshake, result valid and sequencing of DDA loads through
// the increment divider.
// ----------------------------------------------------------------------------
module lr_controller
   import lr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  lr_status_type status,
   output lr_cmd_type    cmd
);

   lr_state_type state_ff, state_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         slot_free, produce;

   always_comb begin
      slot_free    = !rsp_valid_ff || rsp_ready;
      req_ready    = (state_ff == ST_IDLE) && slot_free;
      cmd.accept   = req_valid && req_ready;
      cmd.dda_emit = (state_ff == ST_EMIT) && slot_free;
      produce      = (cmd.accept && !status.dda_long) || cmd.dda_emit;
      if (produce) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.accept && status.dda_long) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (!status.div_busy) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
